/* sv/plist_pkg.sv */
// shared constants and types of the positional list engine
package plist_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INS_FIRST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_LAST  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  found_position;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  element_count;
  } result_t;

endpackage

/* sv/plist_ram.sv */
// simple dual-port ram, one write and one registered read per cycle
module plist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/plist_seq.sv */
// list sequencer: decodes a command and walks the element memory
module plist_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plist_pkg::CMD_W-1:0]    cmd,
  input  logic [plist_pkg::DATA_W-1:0]   value,
  input  logic [plist_pkg::CNT_W-1:0]    position,
  output plist_pkg::mem_req_t            mreq,
  input  logic [plist_pkg::DATA_W-1:0]   rdata,
  output logic                           res_valid,
  input  logic                           res_ready,
  output plist_pkg::result_t             res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_SEARCH,
    S_RDWAIT,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [plist_pkg::CNT_W-1:0]     elem_count;
  logic [plist_pkg::STAT_W-1:0]    status_r;
  logic [plist_pkg::CNT_W-1:0]     fpos_r;
  logic [plist_pkg::DATA_W-1:0]    rval_r;
  logic [plist_pkg::DATA_W-1:0]    val_r;
  logic                            is_ins;
  logic [plist_pkg::ADDR_W-1:0]    idx;
  logic [plist_pkg::ADDR_W-1:0]    ra;
  logic [plist_pkg::CNT_W-1:0]     left;
  logic                            pend;
  logic [plist_pkg::ADDR_W-1:0]    pend_addr;

  logic                            acc;
  logic                            cmd_ins;
  logic [plist_pkg::CNT_W-1:0]     cnt_m1;
  logic [plist_pkg::CNT_W-1:0]     cnt_p1;
  logic [plist_pkg::CNT_W-1:0]     pos_m1;
  logic [plist_pkg::CNT_W-1:0]     ins_idx;
  logic [plist_pkg::CNT_W-1:0]     del_idx;
  logic [plist_pkg::CNT_W-1:0]     del_nxt;
  logic                            ins_bad;
  logic                            pos_bad;
  logic                            full;
  logic                            hit;
  logic [plist_pkg::CNT_W-1:0]     hit_pos;

  assign acc      = (state == S_IDLE) && in_valid;
  assign in_ready = (state == S_IDLE);
  assign cmd_ins  = (cmd == plist_pkg::CMD_INS_FIRST) || (cmd == plist_pkg::CMD_INS_LAST) ||
                    (cmd == plist_pkg::CMD_INS_AT);
  assign cnt_m1   = elem_count - plist_pkg::CNT_W'(1);
  assign cnt_p1   = elem_count + plist_pkg::CNT_W'(1);
  assign pos_m1   = position - plist_pkg::CNT_W'(1);
  assign ins_idx  = (cmd == plist_pkg::CMD_INS_FIRST) ? '0 :
                    (cmd == plist_pkg::CMD_INS_LAST) ? elem_count : pos_m1;
  assign del_idx  = (cmd == plist_pkg::CMD_DEL_FIRST) ? '0 :
                    (cmd == plist_pkg::CMD_DEL_LAST) ? cnt_m1 : pos_m1;
  assign del_nxt  = del_idx + plist_pkg::CNT_W'(1);
  assign ins_bad  = (cmd == plist_pkg::CMD_INS_AT) &&
                    ((position == '0) || (position > cnt_p1));
  assign pos_bad  = (position == '0) || (position > elem_count);
  assign full     = (elem_count == plist_pkg::CAP_COUNT);
  assign hit      = pend && (rdata == val_r);
  assign hit_pos  = plist_pkg::CNT_W'(pend_addr) + plist_pkg::CNT_W'(1);

  // memory port drive
  always_comb begin
    mreq = '0;
    case (state)
      S_IDLE: begin
        if (acc && cmd_ins && !ins_bad && !full && (ins_idx == elem_count)) begin
          mreq.we    = 1'b1;
          mreq.waddr = ins_idx[plist_pkg::ADDR_W-1:0];
          mreq.wdata = value;
        end
        if (acc && (cmd == plist_pkg::CMD_READ)) begin
          mreq.re    = 1'b1;
          mreq.raddr = pos_m1[plist_pkg::ADDR_W-1:0];
        end
      end
      S_SHIFT: begin
        mreq.we    = pend;
        mreq.waddr = pend_addr;
        mreq.wdata = rdata;
        mreq.re    = 1'b1;
        mreq.raddr = ra;
      end
      S_DRAIN: begin
        mreq.we    = 1'b1;
        mreq.waddr = pend_addr;
        mreq.wdata = rdata;
      end
      S_PUT: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx;
        mreq.wdata = val_r;
      end
      S_SEARCH: begin
        mreq.re    = !hit && (left != '0);
        mreq.raddr = ra;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      pend       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            status_r <= plist_pkg::ST_OK;
            fpos_r   <= '0;
            rval_r   <= '0;
            val_r    <= value;
            pend     <= 1'b0;
            if (cmd_ins) begin
              is_ins <= 1'b1;
              idx    <= ins_idx[plist_pkg::ADDR_W-1:0];
              ra     <= cnt_m1[plist_pkg::ADDR_W-1:0];
              left   <= elem_count - ins_idx;
              if (ins_bad) begin
                status_r <= plist_pkg::ST_BADPOS;
                state    <= S_FINISH;
              end else if (full) begin
                status_r <= plist_pkg::ST_FULL;
                state    <= S_FINISH;
              end else if (ins_idx == elem_count) begin
                elem_count <= cnt_p1;
                state      <= S_FINISH;
              end else begin
                state <= S_SHIFT;
              end
            end else if (cmd == plist_pkg::CMD_SEARCH) begin
              ra   <= '0;
              left <= elem_count;
              if (elem_count == '0) begin
                status_r <= plist_pkg::ST_NOTFOUND;
                state    <= S_FINISH;
              end else begin
                state <= S_SEARCH;
              end
            end else if (cmd == plist_pkg::CMD_READ) begin
              if (pos_bad) begin
                status_r <= plist_pkg::ST_BADPOS;
                state    <= S_FINISH;
              end else begin
                state <= S_RDWAIT;
              end
            end else begin
              is_ins <= 1'b0;
              ra     <= del_nxt[plist_pkg::ADDR_W-1:0];
              left   <= cnt_m1 - del_idx;
              if (cmd == plist_pkg::CMD_DEL_AT && pos_bad) begin
                status_r <= plist_pkg::ST_BADPOS;
                state    <= S_FINISH;
              end else if (cmd != plist_pkg::CMD_DEL_AT && elem_count == '0) begin
                status_r <= plist_pkg::ST_EMPTY;
                state    <= S_FINISH;
              end else if (del_idx == cnt_m1) begin
                elem_count <= cnt_m1;
                state      <= S_FINISH;
              end else begin
                state <= S_SHIFT;
              end
            end
          end
        end
        S_SHIFT: begin
          pend      <= 1'b1;
          pend_addr <= is_ins ? ra + plist_pkg::ADDR_W'(1) : ra - plist_pkg::ADDR_W'(1);
          ra        <= is_ins ? ra - plist_pkg::ADDR_W'(1) : ra + plist_pkg::ADDR_W'(1);
          left      <= left - plist_pkg::CNT_W'(1);
          if (left == plist_pkg::CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (is_ins) begin
            state <= S_PUT;
          end else begin
            elem_count <= cnt_m1;
            state      <= S_FINISH;
          end
        end
        S_PUT: begin
          elem_count <= cnt_p1;
          state      <= S_FINISH;
        end
        S_SEARCH: begin
          if (hit) begin
            fpos_r <= hit_pos;
            pend   <= 1'b0;
            state  <= S_FINISH;
          end else if (left == '0) begin
            status_r <= plist_pkg::ST_NOTFOUND;
            pend     <= 1'b0;
            state    <= S_FINISH;
          end else begin
            pend      <= 1'b1;
            pend_addr <= ra;
            ra        <= ra + plist_pkg::ADDR_W'(1);
            left      <= left - plist_pkg::CNT_W'(1);
          end
        end
        S_RDWAIT: begin
          rval_r <= rdata;
          state  <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid          = (state == S_FINISH);
  assign res.status         = status_r;
  assign res.found_position = fpos_r;
  assign res.read_value     = rval_r;
  assign res.element_count  = elem_count;

endmodule

/* sv/positional_list_engine.sv */
// top level of the positional list engine: sequencer, element ram and output register
//
// Ordered list of up to 64 signed 32-bit elements held in one simple dual-port ram.
// One item is taken at a time. Inserts that append, rejected commands, searches of an
// empty list and deletes of the last element go straight to the result, and a read
// waits for its ram read; an insert at 0-based slot i shifts the elements behind it up
// and a delete at slot i shifts the elements behind it down, as the sequencer moves one
// element per cycle through the ram's single write port. A search compares one element
// per ram read and stops at the first match. A finished result waits in the output
// register, so the next item is taken while it is still held by the consumer.
module positional_list_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [plist_pkg::CMD_W-1:0]         cmd,
  input  logic signed [plist_pkg::DATA_W-1:0] value,
  input  logic [plist_pkg::CNT_W-1:0]         position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [plist_pkg::STAT_W-1:0]        status,
  output logic [plist_pkg::CNT_W-1:0]         found_position,
  output logic signed [plist_pkg::DATA_W-1:0] read_value,
  output logic [plist_pkg::CNT_W-1:0]         element_count
);

  plist_pkg::mem_req_t              mreq;
  logic [plist_pkg::DATA_W-1:0]     rdata;
  logic                             res_valid;
  logic                             res_ready;
  plist_pkg::result_t               res;
  plist_pkg::result_t               out_r;

  plist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .value     (value),
    .position  (position),
    .mreq      (mreq),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  plist_ram #(
    .DEPTH (plist_pkg::CAPACITY),
    .WIDTH (plist_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  assign res_ready = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign status         = out_r.status;
  assign found_position = out_r.found_position;
  assign read_value     = out_r.read_value;
  assign element_count  = out_r.element_count;

endmodule

/* sv/plist_checker.sv */
// port checker for the positional list engine and its bind
module plist_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [plist_pkg::STAT_W-1:0]        status,
  input logic [plist_pkg::CNT_W-1:0]         found_position,
  input logic signed [plist_pkg::DATA_W-1:0] read_value,
  input logic [plist_pkg::CNT_W-1:0]         element_count
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(element_count) &&
    $stable(found_position) && $stable(read_value))
    else $error("output beat changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> element_count <= plist_pkg::CAP_COUNT)
    else $error("count above capacity");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == plist_pkg::ST_FULL |-> element_count == plist_pkg::CAP_COUNT)
    else $error("full reported below capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == plist_pkg::ST_EMPTY |-> element_count == '0)
    else $error("empty reported with elements");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_position != '0 |->
      status == plist_pkg::ST_OK && found_position <= element_count)
    else $error("found position out of range");

endmodule

bind positional_list_engine plist_checker u_plist_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .found_position (found_position),
  .read_value     (read_value),
  .element_count  (element_count)
);
